// ===== src/ddd_pkg.sv =====
`default_nettype none

package ddd_pkg;

  localparam int unsigned YearW  = 14;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;
  localparam int unsigned CountW = 23;
  // Day numbers and stage-5 magnitudes both fit in the count width
  localparam int unsigned DnW    = 23;

  localparam logic [CountW-1:0] CountLimit = 23'd3652060;

  localparam logic [MonthW-1:0] MonthFeb = 4'd2;

  typedef struct packed {
    logic [YearW-1:0]  first_year;
    logic [MonthW-1:0] first_month;
    logic [DayW-1:0]   first_day;
    logic [YearW-1:0]  second_year;
    logic [MonthW-1:0] second_month;
    logic [DayW-1:0]   second_day;
    logic              include_end_day;
  } in_t;

  typedef struct packed {
    logic signed [CountW-1:0] day_count;
    logic                     date_invalid;
  } out_t;

  // Length of a month in a common year; zero marks a month code out of range
  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m);
    logic [DayW-1:0] len;
    case (m)
      4'd1:    len = 5'd31;
      4'd2:    len = 5'd28;
      4'd3:    len = 5'd31;
      4'd4:    len = 5'd30;
      4'd5:    len = 5'd31;
      4'd6:    len = 5'd30;
      4'd7:    len = 5'd31;
      4'd8:    len = 5'd31;
      4'd9:    len = 5'd30;
      4'd10:   len = 5'd31;
      4'd11:   len = 5'd30;
      4'd12:   len = 5'd31;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

  // Days before the first of the month in a year that starts on 1 March
  function automatic logic [8:0] month_offset(input logic [MonthW-1:0] m);
    logic [8:0] off;
    case (m)
      4'd3:    off = 9'd0;
      4'd4:    off = 9'd31;
      4'd5:    off = 9'd61;
      4'd6:    off = 9'd92;
      4'd7:    off = 9'd122;
      4'd8:    off = 9'd153;
      4'd9:    off = 9'd184;
      4'd10:   off = 9'd214;
      4'd11:   off = 9'd245;
      4'd12:   off = 9'd275;
      4'd1:    off = 9'd306;
      4'd2:    off = 9'd337;
      default: off = 9'd0;
    endcase
    return off;
  endfunction

endpackage

`default_nettype wire

// ===== src/ddd_day_number.sv =====
`default_nettype none

// Four-stage conversion of one date to an absolute day number, plus date check.
module ddd_day_number (
  input  wire logic                        clk_i,
  input  wire logic [3:0]                  en_i,
  input  wire logic [ddd_pkg::YearW-1:0]   year_i,
  input  wire logic [ddd_pkg::MonthW-1:0]  month_i,
  input  wire logic [ddd_pkg::DayW-1:0]    day_i,
  output logic      [ddd_pkg::DnW-1:0]     dn_o,
  output logic                             ok_o
);

  // Stage 1: reciprocal multiplies for /100 on the year and /400 on the shifted year
  logic [14:0] yy;
  logic [27:0] p100;
  logic [28:0] pera;

  logic [ddd_pkg::YearW-1:0]  y1_q;
  logic [ddd_pkg::MonthW-1:0] m1_q;
  logic [ddd_pkg::DayW-1:0]   d1_q;
  logic [14:0]                yy1_q;
  logic [7:0]                 q100_1_q;
  logic [5:0]                 era1_q;
  logic [8:0]                 doy1_q;

  always_comb begin
    yy   = 15'(year_i) + 15'd400 - ((month_i <= ddd_pkg::MonthFeb) ? 15'd1 : 15'd0);
    p100 = 28'(year_i) * 28'd10486;
    pera = 29'(yy) * 29'd20972;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      y1_q     <= year_i;
      m1_q     <= month_i;
      d1_q     <= day_i;
      yy1_q    <= yy;
      q100_1_q <= p100[27:20];
      era1_q   <= pera[28:23];
      doy1_q   <= ddd_pkg::month_offset(month_i) + 9'(day_i) - 9'd1;
    end
  end

  // Stage 2: leap year, date check, year of era
  logic [6:0]                r100;
  logic                      leap;
  logic [ddd_pkg::DayW-1:0]  len;
  logic [14:0]               yoe_w;

  logic       ok2_q;
  logic [8:0] yoe2_q;
  logic [5:0] era2_q;
  logic [8:0] doy2_q;

  always_comb begin
    r100  = 7'(15'(y1_q) - 15'(q100_1_q) * 15'd100);
    leap  = ((y1_q[1:0] == 2'd0) && (r100 != 7'd0)) ||
            ((r100 == 7'd0) && (q100_1_q[1:0] == 2'd0));
    len   = ((m1_q == ddd_pkg::MonthFeb) && leap) ? 5'd29 : ddd_pkg::month_len(m1_q);
    yoe_w = yy1_q - 15'(era1_q) * 15'd400;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      ok2_q  <= (len != 5'd0) && (d1_q != 5'd0) && (d1_q <= len);
      yoe2_q <= yoe_w[8:0];
      era2_q <= era1_q;
      doy2_q <= doy1_q;
    end
  end

  // Stage 3: era days and day of era
  logic [13:0] p_yoe41;
  logic [17:0] doe;

  logic                      ok3_q;
  logic [ddd_pkg::DnW-1:0]   eday3_q;
  logic [17:0]               doe3_q;

  always_comb begin
    p_yoe41 = 14'(yoe2_q) * 14'd41;
    doe     = 18'(yoe2_q) * 18'd365 + 18'(yoe2_q[8:2]) - 18'(p_yoe41[13:12])
              + 18'(doy2_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      ok3_q   <= ok2_q;
      eday3_q <= ddd_pkg::DnW'(era2_q) * ddd_pkg::DnW'(146097);
      doe3_q  <= doe;
    end
  end

  // Stage 4: day number
  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      ok_o <= ok3_q;
      dn_o <= eday3_q + ddd_pkg::DnW'(doe3_q);
    end
  end

endmodule

`default_nettype wire

// ===== src/date_difference_in_days.sv =====
`default_nettype none

// Channel  Direction  Handshake                Payload
// in       input      in_valid_i / in_stall_o  in_data_i  (ddd_pkg::in_t)
// out      output     out_valid_o / out_stall_i out_data_o (ddd_pkg::out_t)
//
// Six register stages: four convert both dates to day numbers in parallel,
// one takes the magnitude, one saturates, signs and holds the result.
// One transfer per cycle sustained while out_stall_i is low.
// Each stage loads when it is empty or the stage after it loads, so bubbles close up.
// Reset clears the valid bits only.
module date_difference_in_days (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire ddd_pkg::in_t  in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output ddd_pkg::out_t      out_data_o
);

  localparam int unsigned NumStages = 6;

  logic [NumStages-1:0] vld_q;
  logic [NumStages-1:0] en;
  logic [3:0]           inc_q;

  // Load enables, last stage first
  always_comb begin
    en[NumStages-1] = !vld_q[NumStages-1] || !out_stall_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = vld_q[NumStages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= in_valid_i;
      for (int k = 1; k < NumStages; k++) begin
        if (en[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) inc_q[0] <= in_data_i.include_end_day;
    for (int k = 1; k < 4; k++) begin
      if (en[k]) inc_q[k] <= inc_q[k-1];
    end
  end

  logic [ddd_pkg::DnW-1:0] dn_a, dn_b;
  logic                    ok_a, ok_b;

  ddd_day_number u_first (
    .clk_i   (clk_i),
    .en_i    (en[3:0]),
    .year_i  (in_data_i.first_year),
    .month_i (in_data_i.first_month),
    .day_i   (in_data_i.first_day),
    .dn_o    (dn_a),
    .ok_o    (ok_a)
  );

  ddd_day_number u_second (
    .clk_i   (clk_i),
    .en_i    (en[3:0]),
    .year_i  (in_data_i.second_year),
    .month_i (in_data_i.second_month),
    .day_i   (in_data_i.second_day),
    .dn_o    (dn_b),
    .ok_o    (ok_b)
  );

  // Stage 5: magnitude of the difference plus the end day
  logic [ddd_pkg::DnW-1:0] mag5_q;
  logic                    neg5_q;
  logic                    ok5_q;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      neg5_q <= dn_a > dn_b;
      ok5_q  <= ok_a && ok_b;
      mag5_q <= ((dn_a > dn_b) ? (dn_a - dn_b) : (dn_b - dn_a))
                + ddd_pkg::DnW'(inc_q[3]);
    end
  end

  // Stage 6: saturate, sign, flag invalid dates
  logic [ddd_pkg::CountW-1:0] sat;

  always_comb begin
    sat = (mag5_q > ddd_pkg::CountLimit) ? ddd_pkg::CountLimit
                                         : ddd_pkg::CountW'(mag5_q);
  end

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      out_data_o.date_invalid <= !ok5_q;
      if (!ok5_q) begin
        out_data_o.day_count <= '0;
      end else if (neg5_q) begin
        out_data_o.day_count <= -$signed(sat);
      end else begin
        out_data_o.day_count <= $signed(sat);
      end
    end
  end

  a_invalid_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.date_invalid |-> out_data_o.day_count == '0)
    else $error("invalid date with non-zero count");

  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.day_count <= $signed(ddd_pkg::CountLimit)) &&
                    (out_data_o.day_count >= -$signed(ddd_pkg::CountLimit)))
    else $error("count beyond limit");

  a_stall_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> &vld_q)
    else $error("input stalled with a bubble in the pipeline");

  a_stall_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

endmodule

`default_nettype wire
